### hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_TEXT   = 2'd2;
    localparam logic [1:0] FUNC_END    = 2'd3;

    localparam logic [7:0] STAR_BYTE = 8'd42;

    // Command that the top level broadcasts to every cell of the row.
    typedef struct packed {
        logic       restart;  // go back to the closure of position zero
        logic       text;     // advance the active positions by one text byte
        logic [7:0] ch;       // pattern byte to load or text byte to compare
    } t_cell_cmd;

endpackage

### hw/rtl/swm_in_if.sv
`timescale 1ns / 1ps

interface swm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] ch;

    modport source (output valid, output func, output ch, input ready);
    modport sink   (input valid, input func, input ch, output ready);
endinterface

### hw/rtl/swm_out_if.sv
`timescale 1ns / 1ps

interface swm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### hw/rtl/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head,       // high for the cell of position zero
    input  t_cell_cmd i_cmd,
    input  logic      i_wr,         // load i_cmd.ch into this cell
    input  logic      i_valid,      // cell lies inside the current pattern
    input  logic      i_valid_nxt,  // cell lies inside the pattern after this beat
    input  logic      i_fwd,        // left neighbor consumed the text byte
    input  logic      i_close,      // left neighbor is active after this beat and sits on a star
    output logic      o_fwd,
    output logic      o_close,
    output logic      o_act
);

    logic [7:0] r_byte;
    logic       r_act;
    logic       n_act;
    logic       w_star_cur;
    logic       w_star_nxt;
    logic       w_base;
    logic [7:0] w_byte_nxt;

    assign w_byte_nxt = i_wr ? i_cmd.ch : r_byte;
    assign w_star_cur = i_valid && (r_byte == STAR_BYTE);
    assign w_star_nxt = i_valid_nxt && (w_byte_nxt == STAR_BYTE);

    // A star keeps its own position alive; a literal hands the match to the right.
    assign o_fwd = r_act && i_valid && !w_star_cur && (r_byte == i_cmd.ch);

    always_comb begin
        if (i_cmd.restart) begin
            w_base = i_head;
        end else if (i_cmd.text) begin
            w_base = (r_act && w_star_cur) || i_fwd;
        end else begin
            w_base = r_act;
        end
    end

    // Closure over stars ripples along the row within the same cycle.
    assign n_act   = w_base || ((i_cmd.restart || i_cmd.text) && i_close);
    assign o_close = n_act && w_star_nxt;
    assign o_act   = r_act;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_byte <= i_cmd.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_head;
        end else begin
            r_act <= n_act;
        end
    end

endmodule

### hw/rtl/star_wildcard_matcher_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Beat payload                  | Note
// i_in     | in  | func[1:0], ch[7:0]            | clear, append, text byte, end
// o_out    | out | matched, pattern_overflow     | one beat per end item
//
// A new beat may be accepted in every cycle in which the input is not stalled.
// Each pattern byte lives in its own cell, and a text byte updates all cells
// at once; star closure ripples through the row of PATTERN_MAX cells.
// The result of an end beat sits in an output register in the cycle after the beat is accepted.
// Input is stalled only while that register is full and not being taken.
// Reset is synchronous; it empties the pattern and needs no clearing pass.

module star_wildcard_matcher_top
    import swm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    swm_in_if.sink          i_in,
    swm_out_if.source       o_out
);

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic [LW-1:0]        r_len;
    logic [LW-1:0]        n_len;
    logic                 r_text_seen;
    logic                 r_ovf;
    logic                 r_tail_act;
    logic                 n_tail_act;
    logic                 r_out_valid;
    logic                 r_matched;
    logic                 r_out_ovf;

    logic                 w_acc;
    logic                 w_append;
    logic                 w_full;
    t_cell_cmd            w_cmd;
    logic [PATTERN_MAX-1:0] w_wr;
    logic [PATTERN_MAX-1:0] w_valid;
    logic [PATTERN_MAX-1:0] w_valid_nxt;
    logic [PATTERN_MAX:0]   w_fwd;
    logic [PATTERN_MAX:0]   w_close;
    logic [PATTERN_MAX:0]   w_act;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_full     = (r_len == LW'(PATTERN_MAX));
    assign w_append   = w_acc && (i_in.func == FUNC_APPEND);

    assign w_cmd.restart = w_acc && (i_in.func != FUNC_TEXT);
    assign w_cmd.text    = w_acc && (i_in.func == FUNC_TEXT);
    assign w_cmd.ch      = i_in.ch;

    always_comb begin
        n_len = r_len;
        if (w_acc && (i_in.func == FUNC_CLEAR)) begin
            n_len = '0;
        end else if (w_append && !w_full) begin
            n_len = r_len + LW'(1);
        end
    end

    assign w_fwd[0]   = 1'b0;
    assign w_close[0] = 1'b0;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        assign w_valid[g]     = (LW'(g) < r_len);
        assign w_valid_nxt[g] = (LW'(g) < n_len);
        assign w_wr[g]        = w_append && (r_len == LW'(g));

        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_head      (g == 0),
            .i_cmd       (w_cmd),
            .i_wr        (w_wr[g]),
            .i_valid     (w_valid[g]),
            .i_valid_nxt (w_valid_nxt[g]),
            .i_fwd       (w_fwd[g]),
            .i_close     (w_close[g]),
            .o_fwd       (w_fwd[g+1]),
            .o_close     (w_close[g+1]),
            .o_act       (w_act[g])
        );
    end

    // Position PATTERN_MAX has no byte of its own: it is only reached.
    always_comb begin
        if (w_cmd.restart) begin
            n_tail_act = w_close[PATTERN_MAX];
        end else if (w_cmd.text) begin
            n_tail_act = w_fwd[PATTERN_MAX] || w_close[PATTERN_MAX];
        end else begin
            n_tail_act = r_tail_act;
        end
    end

    assign w_act[PATTERN_MAX] = r_tail_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_text_seen <= 1'b0;
            r_ovf       <= 1'b0;
            r_tail_act  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_tail_act <= n_tail_act;
            if (w_acc) begin
                r_text_seen <= (i_in.func == FUNC_TEXT);
            end
            if (w_acc && (i_in.func == FUNC_CLEAR)) begin
                r_ovf <= 1'b0;
            end else if (w_append && w_full) begin
                r_ovf <= 1'b1;
            end
            if (w_acc && (i_in.func == FUNC_END)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_in.func == FUNC_END)) begin
            r_matched <= (r_len != '0) && r_text_seen && w_act[r_len];
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_overflow = r_out_ovf;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import swm_pkg::*;

    localparam int          PMAX       = 32;
    localparam int          N_BEATS    = 1750;
    localparam int unsigned CYCLE_CAP  = 200000;
    localparam int          HOLD_CYCLES = 500;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    // Tracks the pattern and the live NFA positions, and queues the verdict
    // that each end beat should produce.
    class match_scoreboard;
        logic [7:0]    pat_bytes [PMAX];
        int unsigned   pat_len;
        logic [PMAX:0] live_pos;
        bit            text_open;
        bit            dropped;
        verdict_t      verdicts_due [$];
        int unsigned   errors;
        int unsigned   results_seen;

        function new();
            pat_len      = 0;
            dropped      = 0;
            errors       = 0;
            results_seen = 0;
            restart();
        endfunction

        // A live position on a star may also skip the star.
        function logic [PMAX:0] close_stars(logic [PMAX:0] v);
            for (int i = 0; i < pat_len; i++) begin
                if (v[i] && pat_bytes[i] == STAR_BYTE) v[i+1] = 1'b1;
            end
            return v;
        endfunction

        function void restart();
            live_pos  = close_stars({{PMAX{1'b0}}, 1'b1});
            text_open = 0;
        endfunction

        function void note_beat(logic [1:0] f, logic [7:0] c);
            logic [PMAX:0] nxt;
            verdict_t      v;
            case (f)
                FUNC_CLEAR: begin
                    pat_len = 0;
                    dropped = 0;
                    restart();
                end
                FUNC_APPEND: begin
                    if (pat_len < PMAX) begin
                        pat_bytes[pat_len] = c;
                        pat_len++;
                    end else begin
                        dropped = 1;
                    end
                    restart();
                end
                FUNC_TEXT: begin
                    nxt = '0;
                    for (int i = 0; i < pat_len; i++) begin
                        if (live_pos[i]) begin
                            if (pat_bytes[i] == STAR_BYTE) nxt[i] = 1'b1;
                            else if (pat_bytes[i] == c) nxt[i+1] = 1'b1;
                        end
                    end
                    live_pos  = close_stars(nxt);
                    text_open = 1;
                end
                default: begin
                    v.matched  = (pat_len > 0) && text_open && live_pos[pat_len];
                    v.overflow = dropped;
                    verdicts_due.push_back(v);
                    restart();
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_verdict(logic m, logic o);
            verdict_t w;
            results_seen++;
            if (verdicts_due.size() == 0) begin
                report($sformatf("result %0d with none pending: matched=%0b overflow=%0b",
                                 results_seen, m, o));
                return;
            end
            w = verdicts_due.pop_front();
            if (m !== w.matched)
                report($sformatf("result %0d matched=%0b, predicted %0b",
                                 results_seen, m, w.matched));
            if (o !== w.overflow)
                report($sformatf("result %0d pattern_overflow=%0b, predicted %0b",
                                 results_seen, o, w.overflow));
        endtask

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    swm_in_if  in_if ();
    swm_out_if out_if ();

    star_wildcard_matcher_top #(
        .PATTERN_MAX(PMAX)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    match_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          beats_sent  = 0;
    int          hold_left   = 0;
    bit          hold_go     = 0;
    bit          hold_done   = 0;
    bit          calm        = 0;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off so that the
    // output register fills and the input stalls.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                sb.check_verdict(out_if.matched, out_if.pattern_overflow);
            if (hold_go) begin
                hold_left = HOLD_CYCLES;
                hold_go   = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    task automatic send_beat(input logic [1:0] f, input logic [7:0] c);
        while (!calm && $urandom_range(0, 99) < 29) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func  <= f;
        in_if.ch    <= c;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_beat(f, c);
        beats_sent++;
    endtask

    function automatic logic [7:0] pick_pattern_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'h61;
        if (r < 55) return 8'h62;
        if (r < 80) return STAR_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'h61;
        if (r < 80) return 8'h62;
        if (r < 90) return STAR_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Builds a text that matches the stored pattern, then damages it now and
    // then so that misses show up as well.
    function automatic byte_q_t make_text(byte_q_t pat);
        byte_q_t t;
        foreach (pat[i]) begin
            if (pat[i] == STAR_BYTE) begin
                repeat ($urandom_range(0, 3)) t.push_back(pick_text_byte());
            end else begin
                t.push_back(pat[i]);
            end
        end
        if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 2))
                0: if (t.size() > 0) t[$urandom_range(0, t.size() - 1)] = pick_text_byte();
                1: if (t.size() > 0) t.delete($urandom_range(0, t.size() - 1));
                default: t.push_back(pick_text_byte());
            endcase
        end
        return t;
    endfunction

    task automatic run_sequence();
        byte_q_t     pat;
        byte_q_t     txt;
        int unsigned plen;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
        send_beat(FUNC_CLEAR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < plen; i++) begin
            pat.push_back(pick_pattern_byte());
            send_beat(FUNC_APPEND, pat[i]);
        end
        // Bytes past the store are dropped, so texts follow the kept prefix.
        while (pat.size() > PMAX) void'(pat.pop_back());
        repeat ($urandom_range(1, 4)) begin
            txt = make_text(pat);
            foreach (txt[k]) send_beat(FUNC_TEXT, txt[k]);
            send_beat(FUNC_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.func  <= FUNC_CLEAR;
        in_if.ch    <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty pattern and empty text after reset.
        send_beat(FUNC_END, 8'hFF);
        // One-byte pattern: empty text misses, then a hit.
        send_beat(FUNC_CLEAR, 8'h00);
        send_beat(FUNC_APPEND, 8'h61);
        send_beat(FUNC_END, 8'h00);
        send_beat(FUNC_TEXT, 8'h61);
        send_beat(FUNC_END, 8'h00);
        // A run of trailing stars against an exhausted text, then empty text.
        send_beat(FUNC_CLEAR, 8'hFF);
        send_beat(FUNC_APPEND, STAR_BYTE);
        send_beat(FUNC_APPEND, STAR_BYTE);
        send_beat(FUNC_TEXT, 8'h78);
        send_beat(FUNC_END, 8'hFF);
        send_beat(FUNC_END, 8'h00);
        // Extreme byte values as literals.
        send_beat(FUNC_CLEAR, 8'h00);
        send_beat(FUNC_APPEND, 8'h00);
        send_beat(FUNC_APPEND, 8'hFF);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_END, 8'h00);
        // A pattern byte in the middle of a text throws that text away.
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_APPEND, STAR_BYTE);
        send_beat(FUNC_TEXT, 8'h00);
        send_beat(FUNC_TEXT, 8'hFF);
        send_beat(FUNC_TEXT, STAR_BYTE);
        send_beat(FUNC_END, 8'hFF);

        while (beats_sent < N_BEATS) begin
            if (!hold_done && beats_sent >= 700) begin
                hold_go   = 1;
                hold_done = 1;
            end
            calm = (beats_sent >= 1000 && beats_sent < 1300);
            if ($urandom_range(0, 99) < 78) run_sequence();
            else run_noise();
        end
        calm = 0;
        in_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
